>>> hw/rtl/c_subset_tokenizer_defines.svh
// assertion macros for the tokenizer
`ifndef C_SUBSET_TOKENIZER_DEFINES_SVH
`define C_SUBSET_TOKENIZER_DEFINES_SVH
// implication checked every clock outside reset
`define CST_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");
// implication checked in the cycle after the antecedent
`define CST_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("lbl");
`endif

>>> hw/rtl/cst_pkg.sv
// shared types and constants of the tokenizer
package cst_pkg;
  localparam logic [3:0] T_KW = 4'd0, T_IDENT = 4'd1, T_OP = 4'd2, T_DELIM = 4'd3,
    T_INT = 4'd4, T_FLOAT = 4'd5, T_STRING = 4'd6, T_BOOL = 4'd7, T_ERROR = 4'd8,
    T_END = 4'd9;
  localparam logic [2:0] E_NONE = 3'd0, E_DOTS = 3'd1, E_LETTERS = 3'd2, E_UNTERM = 3'd3,
    E_PUNCT = 3'd4, E_CHAR = 3'd5;
  localparam logic [2:0] M_IDLE = 3'd0, M_IDENT = 3'd1, M_NUMBER = 3'd2, M_SWALLOW = 3'd3,
    M_STRING = 3'd4, M_DIRECTIVE = 3'd5, M_PUNCT = 3'd6;
  localparam int NKW = 18;
  localparam int KW_CHARS = 9;

  function automatic logic [7:0] kw_char(input int k, input int p);
    logic [71:0] s;
    begin
      unique case (k)
        0: s = {"int", 48'd0};
        1: s = {"bool", 40'd0};
        2: s = {"return", 24'd0};
        3: s = {"if", 56'd0};
        4: s = {"else", 40'd0};
        5: s = {"for", 48'd0};
        6: s = {"while", 32'd0};
        7: s = {"using", 32'd0};
        8: s = "namespace";
        9: s = {"include", 16'd0};
        10: s = {"true", 40'd0};
        11: s = {"false", 32'd0};
        12: s = {"cout", 40'd0};
        13: s = {"cin", 48'd0};
        14: s = {"endl", 40'd0};
        15: s = {"std", 48'd0};
        16: s = {"string", 24'd0};
        default: s = {"iostream", 8'd0};
      endcase
      kw_char = (p < KW_CHARS) ? s[71 - 8 * p -: 8] : 8'd0;
    end
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] l;
    begin
      unique case (k)
        0, 5, 13, 15: l = 4'd3;
        1, 4, 10, 12, 14: l = 4'd4;
        2, 16: l = 4'd6;
        3: l = 4'd2;
        6, 7, 11: l = 4'd5;
        8: l = 4'd9;
        9: l = 4'd7;
        default: l = 4'd8;
      endcase
      kw_len = l;
    end
  endfunction

  function automatic logic [3:0] kw_type(input int k);
    begin
      if (k == 10 || k == 11) kw_type = T_BOOL;
      else if (k == 12 || k == 13 || k == 14 || k == 15 || k == 17) kw_type = T_IDENT;
      else kw_type = T_KW;
    end
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    is_space = c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic logic is_punct(input logic [7:0] c);
    is_punct = (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction
  function automatic logic pair_starter(input logic [7:0] c);
    pair_starter = c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|" ||
                   c == "+" || c == "-" || c == ":";
  endfunction
  function automatic logic [3:0] single_type(input logic [7:0] c);
    begin
      case (c)
        "=", "+", "-", "*", "/", "%", "<", ">", "!": single_type = T_OP;
        ";", "{", "}", "(", ")", ",", ":": single_type = T_DELIM;
        default: single_type = T_ERROR;
      endcase
    end
  endfunction
  function automatic logic [3:0] pair_type(input logic [7:0] a, input logic [7:0] b);
    begin
      if (b == "=" && (a == "=" || a == "!" || a == "<" || a == ">" || a == "+" || a == "-"))
        pair_type = T_OP;
      else if (a == b && (a == "&" || a == "|" || a == "+" || a == "-" || a == "<" || a == ">"))
        pair_type = T_OP;
      else if (a == ":" && b == ":") pair_type = T_DELIM;
      else pair_type = T_ERROR;
    end
  endfunction
endpackage

>>> hw/rtl/c_subset_tokenizer.sv
// streaming tokenizer for a small c-like language
//  channel | signals                         | direction
//  input   | valid, stall, kind, ch           | in
//  output  | out_valid, out_stall, token ...  | out
// one byte per cycle while each byte gives at most one token and the output is not stalled
// a token is offered the cycle after its byte is taken
// a byte can produce two tokens, held in a two-entry result queue; input then stalls while they drain
// input stall rises when the queue cannot take two more tokens
// reset returns the scan state and counters to the start of a source
`include "c_subset_tokenizer_defines.svh"
module c_subset_tokenizer
  import cst_pkg::*;
#(
  parameter int LINE_WIDTH = 16,
  parameter int COLUMN_WIDTH = 16,
  parameter int LENGTH_WIDTH = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic        kind,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_type,
  output logic [15:0] start_line,
  output logic [15:0] start_column,
  output logic [31:0] start_offset,
  output logic [15:0] lexeme_length,
  output logic [2:0]  error_code,
  output logic        last
);
  localparam int RW = 4 + 16 + 16 + 32 + 16 + 3 + 1;
  localparam logic [LINE_WIDTH-1:0] LINE_ONE = LINE_WIDTH'(1);
  localparam logic [COLUMN_WIDTH-1:0] COL_ONE = COLUMN_WIDTH'(1);

  logic [2:0] mode, mode_next;
  logic [LINE_WIDTH-1:0] line_count, tok_line, tok_line_next;
  logic [COLUMN_WIDTH-1:0] column_count, tok_column, tok_column_next;
  logic [OFFSET_WIDTH-1:0] offset_count, tok_offset, tok_offset_next;
  logic [LENGTH_WIDTH-1:0] tok_length, tok_length_next;
  logic [NKW-1:0] keyword_hits, keyword_hits_next;
  logic seen_dot, seen_dot_next;
  logic [7:0] held_char, held_char_next;

  // result queue
  logic [RW-1:0] q0, q1;
  logic [1:0] qcount;

  logic accept, pop;
  logic [1:0] n;
  logic [RW-1:0] r0, r1;

  assign stall = qcount != 2'd0 && !(qcount == 2'd1 && pop);
  assign accept = valid && !stall;
  assign out_valid = qcount != 2'd0;
  assign pop = out_valid && !out_stall;
  assign {token_type, start_line, start_column, start_offset, lexeme_length, error_code,
          last} = q0;

  logic [LENGTH_WIDTH-1:0] len_inc;
  assign len_inc = (&tok_length) ? tok_length : tok_length + LENGTH_WIDTH'(1);

  always_comb begin
    logic again;
    logic [3:0] it, st, pt;
    logic [LENGTH_WIDTH-1:0] l0;
    logic [NKW-1:0] fh;
    logic [LENGTH_WIDTH-1:0] ilen;
    logic [RW-1:0] res;
    logic [3:0] e_type;
    logic [LENGTH_WIDTH-1:0] e_len;
    logic [2:0] e_err;
    logic e_do;
    again = 1'b0;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    res = '0;
    mode_next = mode;
    tok_line_next = tok_line;
    tok_column_next = tok_column;
    tok_offset_next = tok_offset;
    tok_length_next = tok_length;
    keyword_hits_next = keyword_hits;
    seen_dot_next = seen_dot;
    held_char_next = held_char;
    e_do = 1'b0;
    e_type = T_ERROR;
    e_len = tok_length;
    e_err = E_NONE;
    // identifier classification of the pending token
    it = T_IDENT;
    for (int i = 0; i < NKW; i++)
      if (keyword_hits[i] && LENGTH_WIDTH'(kw_len(i)) == tok_length) it = kw_type(i);
    st = single_type(held_char);
    pt = pair_type(held_char, ch);
    if (kind) begin
      unique case (mode)
        M_IDENT: begin e_do = 1'b1; e_type = it; end
        M_NUMBER: begin e_do = 1'b1; e_type = seen_dot ? T_FLOAT : T_INT; end
        M_STRING: begin e_do = 1'b1; e_type = T_ERROR; e_err = E_UNTERM; end
        M_PUNCT: begin
          e_do = 1'b1; e_type = st; e_len = LENGTH_WIDTH'(1);
          e_err = (st == T_ERROR) ? E_PUNCT : E_NONE;
        end
        default: ;
      endcase
    end else begin
      unique case (mode)
        M_IDENT:
          if (is_alpha(ch) || is_digit(ch) || ch == "_") begin
            for (int i = 0; i < NKW; i++)
              if (!(tok_length < LENGTH_WIDTH'(kw_len(i)) &&
                    kw_char(i, int'(tok_length[3:0])) == ch))
                keyword_hits_next[i] = 1'b0;
            tok_length_next = len_inc;
          end else begin
            e_do = 1'b1; e_type = it; again = 1'b1;
          end
        M_NUMBER:
          if (is_digit(ch)) tok_length_next = len_inc;
          else if (ch == ".") begin
            if (seen_dot) begin
              e_do = 1'b1; e_len = len_inc; e_err = E_DOTS; again = 1'b1;
            end else begin
              seen_dot_next = 1'b1; tok_length_next = len_inc;
            end
          end else if (is_alpha(ch)) begin
            e_do = 1'b1; e_err = E_LETTERS; mode_next = M_SWALLOW;
          end else begin
            e_do = 1'b1; e_type = seen_dot ? T_FLOAT : T_INT; again = 1'b1;
          end
        M_SWALLOW: again = !(is_alpha(ch) || is_digit(ch));
        M_STRING:
          if (ch == "\"") begin
            e_do = 1'b1; e_type = T_STRING; mode_next = M_IDLE;
          end else if (ch == 8'd10) begin
            e_do = 1'b1; e_err = E_UNTERM; again = 1'b1;
          end else tok_length_next = len_inc;
        M_DIRECTIVE: again = ch == 8'd10;
        M_PUNCT:
          if (pt != T_ERROR) begin
            e_do = 1'b1; e_type = pt; e_len = LENGTH_WIDTH'(2); mode_next = M_IDLE;
          end else begin
            e_do = 1'b1; e_type = st; e_len = LENGTH_WIDTH'(1);
            e_err = (st == T_ERROR) ? E_PUNCT : E_NONE; again = 1'b1;
          end
        default: again = 1'b1;
      endcase
    end
    l0 = e_len;
    if (e_do) begin
      r0 = {e_type, 16'(tok_line), 16'(tok_column), 32'(tok_offset), 16'(l0), e_err, 1'b0};
      n = 2'd1;
    end
    // second token starts from the fresh scan or end marker
    e_do = 1'b0;
    e_type = T_ERROR;
    e_len = LENGTH_WIDTH'(1);
    e_err = E_NONE;
    fh = '1;
    ilen = LENGTH_WIDTH'(1);
    if (kind) begin
      e_do = 1'b1; e_type = T_END; e_len = '0;
      mode_next = M_IDLE;
      tok_length_next = '0;
      keyword_hits_next = '1;
      seen_dot_next = 1'b0;
      held_char_next = '0;
      tok_line_next = LINE_ONE;
      tok_column_next = COL_ONE;
      tok_offset_next = '0;
    end else if (again) begin
      tok_line_next = line_count;
      tok_column_next = column_count;
      tok_offset_next = offset_count;
      tok_length_next = '0;
      mode_next = M_IDLE;
      if (is_space(ch)) ;
      else if (ch == "#") mode_next = M_DIRECTIVE;
      else if (is_alpha(ch) || ch == "_") begin
        mode_next = M_IDENT;
        for (int i = 0; i < NKW; i++)
          if (kw_char(i, 0) != ch) fh[i] = 1'b0;
        keyword_hits_next = fh;
        tok_length_next = ilen;
      end else if (is_digit(ch)) begin
        mode_next = M_NUMBER; seen_dot_next = 1'b0; tok_length_next = LENGTH_WIDTH'(1);
      end else if (ch == "\"") mode_next = M_STRING;
      else if (is_punct(ch)) begin
        if (pair_starter(ch)) begin
          mode_next = M_PUNCT; held_char_next = ch;
        end else begin
          e_do = 1'b1; e_type = single_type(ch);
          e_err = (e_type == T_ERROR) ? E_PUNCT : E_NONE;
        end
      end else begin
        e_do = 1'b1; e_err = E_CHAR;
      end
    end
    if (e_do) begin
      res = {e_type, 16'(line_count), 16'(column_count), 32'(offset_count), 16'(e_len),
             e_err, 1'b0};
      if (n == 2'd0) r0 = res;
      else r1 = res;
      n = n + 2'd1;
    end
    if (n == 2'd1) r0[0] = 1'b1;
    if (n == 2'd2) r1[0] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      line_count <= LINE_ONE;
      column_count <= COL_ONE;
      offset_count <= '0;
      tok_line <= LINE_ONE;
      tok_column <= COL_ONE;
      tok_offset <= '0;
      tok_length <= '0;
      keyword_hits <= '1;
      seen_dot <= 1'b0;
      held_char <= '0;
      qcount <= 2'd0;
    end else begin
      if (accept) begin
        mode <= mode_next;
        tok_line <= tok_line_next;
        tok_column <= tok_column_next;
        tok_offset <= tok_offset_next;
        tok_length <= tok_length_next;
        keyword_hits <= keyword_hits_next;
        seen_dot <= seen_dot_next;
        held_char <= held_char_next;
        if (kind) begin
          line_count <= LINE_ONE;
          column_count <= COL_ONE;
          offset_count <= '0;
        end else begin
          if (!(&offset_count)) offset_count <= offset_count + OFFSET_WIDTH'(1);
          if (ch == 8'd10) begin
            if (!(&line_count)) line_count <= line_count + LINE_WIDTH'(1);
            column_count <= COL_ONE;
          end else if (!(&column_count)) column_count <= column_count + COLUMN_WIDTH'(1);
        end
      end
      qcount <= qcount - {1'b0, pop} + (accept ? n : 2'd0);
    end
  end

  // queue payload: accept only happens when queue is empty or draining its last entry
  always_ff @(posedge clk) begin
    if (pop && qcount == 2'd2) q0 <= q1;
    if (accept) begin
      q0 <= r0;
      q1 <= r1;
    end
  end

  `CST_ASSERT_IMP(a_no_overflow, 1'b1, qcount != 2'd3)
  `CST_ASSERT_IMP(a_stall_when_full, qcount == 2'd2, stall)
  `CST_ASSERT_NEXT(a_end_resets, accept && kind, mode == M_IDLE && offset_count == '0)
endmodule

>>> tb/tb_top.sv
// testbench for the c subset tokenizer: directed and random byte streams, checked per token
`timescale 1ns / 1ps
module tb_top
  import cst_pkg::*;
();

  typedef struct packed {
    logic [3:0]  ttype;
    logic [15:0] line;
    logic [15:0] col;
    logic [31:0] offs;
    logic [15:0] len;
    logic [2:0]  err;
    logic        lst;
  } token_t;

  logic clk, rst;
  logic valid, stall, kind;
  logic [7:0] ch;
  logic out_valid, out_stall;
  logic [3:0] token_type;
  logic [15:0] start_line, start_column, lexeme_length;
  logic [31:0] start_offset;
  logic [2:0] error_code;
  logic last;

  c_subset_tokenizer dut (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall), .kind(kind), .ch(ch),
    .out_valid(out_valid), .out_stall(out_stall), .token_type(token_type),
    .start_line(start_line), .start_column(start_column), .start_offset(start_offset),
    .lexeme_length(lexeme_length), .error_code(error_code), .last(last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // scanner state mirror
  logic [2:0]  scan_mode;
  logic [15:0] cur_line, cur_col, tk_line, tk_col, tk_len;
  logic [31:0] cur_offs, tk_offs;
  logic [NKW-1:0] kw_alive;
  logic dot_seen;
  logic [7:0] held;

  token_t expected_tokens[$];
  token_t step_out[$];
  int mismatches = 0;
  int send_idle_pct = 0, stall_pct = 0, hold_cycles = 0;
  longint cycles = 0;

  function automatic logic [15:0] inc16(logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic logic [31:0] inc32(logic [31:0] v);
    return (v == 32'hffffffff) ? v : v + 32'd1;
  endfunction

  function automatic logic [3:0] lone_type(logic [7:0] c);
    case (c)
      "=", "+", "-", "*", "/", "%", "<", ">", "!": return T_OP;
      ";", "{", "}", "(", ")", ",", ":": return T_DELIM;
      default: return T_ERROR;
    endcase
  endfunction

  function automatic logic [3:0] two_char_type(logic [7:0] a, logic [7:0] b);
    if (b == "=" && (a == "=" || a == "!" || a == "<" || a == ">" || a == "+" || a == "-"))
      return T_OP;
    if (a == b && (a == "&" || a == "|" || a == "+" || a == "-" || a == "<" || a == ">"))
      return T_OP;
    if (a == ":" && b == ":") return T_DELIM;
    return T_ERROR;
  endfunction

  function automatic bit starts_pair(logic [7:0] c);
    return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|" ||
      c == "+" || c == "-" || c == ":";
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit punct(logic [7:0] c);
    return (c >= 33 && c <= 47) || (c >= 58 && c <= 64) || (c >= 91 && c <= 96) ||
      (c >= 123 && c <= 126);
  endfunction

  function automatic string word_text(int k);
    string w[NKW] = '{"int", "bool", "return", "if", "else", "for", "while", "using",
      "namespace", "include", "true", "false", "cout", "cin", "endl", "std", "string",
      "iostream"};
    return w[k];
  endfunction

  function automatic logic [3:0] word_type(int k);
    if (k == 10 || k == 11) return T_BOOL;
    if (k == 12 || k == 13 || k == 14 || k == 15 || k == 17) return T_IDENT;
    return T_KW;
  endfunction

  task automatic push_token(logic [3:0] t, logic [15:0] len, logic [2:0] e);
    token_t r;
    r.ttype = t; r.line = tk_line; r.col = tk_col; r.offs = tk_offs;
    r.len = len; r.err = e; r.lst = 1'b0;
    if (step_out.size() < 2) step_out = {step_out, r};
  endtask

  task automatic push_lone(logic [7:0] c);
    logic [3:0] t;
    t = lone_type(c);
    push_token(t, 16'd1, (t == T_ERROR) ? E_PUNCT : E_NONE);
  endtask

  task automatic word_add(logic [7:0] c);
    string w;
    for (int i = 0; i < NKW; i++) begin
      w = word_text(i);
      if (kw_alive[i] && !(tk_len < w.len() && w[tk_len] == c)) kw_alive[i] = 1'b0;
    end
    tk_len = inc16(tk_len);
  endtask

  task automatic word_finish();
    logic [3:0] t;
    string w;
    t = T_IDENT;
    for (int i = 0; i < NKW; i++) begin
      w = word_text(i);
      if (kw_alive[i] && w.len() == tk_len) t = word_type(i);
    end
    push_token(t, tk_len, E_NONE);
  endtask

  task automatic scanner_reset();
    scan_mode = M_IDLE;
    cur_line = 1; cur_col = 1; cur_offs = 0;
    tk_line = 1; tk_col = 1; tk_offs = 0; tk_len = 0;
    kw_alive = '1; dot_seen = 0; held = 0;
  endtask

  task automatic scan_fresh(logic [7:0] c);
    tk_line = cur_line; tk_col = cur_col; tk_offs = cur_offs; tk_len = 0;
    scan_mode = M_IDLE;
    if (c == " " || (c >= 9 && c <= 13)) return;
    if (c == "#") begin
      scan_mode = M_DIRECTIVE;
    end else if (letter(c) || c == "_") begin
      scan_mode = M_IDENT; kw_alive = '1; word_add(c);
    end else if (digit(c)) begin
      scan_mode = M_NUMBER; dot_seen = 0; tk_len = 1;
    end else if (c == "\"") begin
      scan_mode = M_STRING;
    end else if (punct(c)) begin
      if (starts_pair(c)) begin
        scan_mode = M_PUNCT; held = c;
      end else push_lone(c);
    end else push_token(T_ERROR, 16'd1, E_CHAR);
  endtask

  // predicts the tokens caused by one transaction and queues them
  task automatic predict_tokens(logic k, logic [7:0] c);
    bit again;
    logic [3:0] t;
    again = 0;
    step_out.delete();
    if (k) begin
      case (scan_mode)
        M_IDENT: word_finish();
        M_NUMBER: push_token(dot_seen ? T_FLOAT : T_INT, tk_len, E_NONE);
        M_STRING: push_token(T_ERROR, tk_len, E_UNTERM);
        M_PUNCT: push_lone(held);
        default: ;
      endcase
      tk_line = cur_line; tk_col = cur_col; tk_offs = cur_offs;
      push_token(T_END, 16'd0, E_NONE);
      scanner_reset();
    end else begin
      case (scan_mode)
        M_IDENT:
          if (letter(c) || digit(c) || c == "_") word_add(c);
          else begin
            word_finish(); again = 1;
          end
        M_NUMBER:
          if (digit(c)) tk_len = inc16(tk_len);
          else if (c == ".") begin
            if (dot_seen) begin
              push_token(T_ERROR, inc16(tk_len), E_DOTS); again = 1;
            end else begin
              dot_seen = 1; tk_len = inc16(tk_len);
            end
          end else if (letter(c)) begin
            push_token(T_ERROR, tk_len, E_LETTERS); scan_mode = M_SWALLOW;
          end else begin
            push_token(dot_seen ? T_FLOAT : T_INT, tk_len, E_NONE); again = 1;
          end
        M_SWALLOW: if (!(letter(c) || digit(c))) again = 1;
        M_STRING:
          if (c == "\"") begin
            push_token(T_STRING, tk_len, E_NONE); scan_mode = M_IDLE;
          end else if (c == 8'd10) begin
            push_token(T_ERROR, tk_len, E_UNTERM); again = 1;
          end else tk_len = inc16(tk_len);
        M_DIRECTIVE: if (c == 8'd10) again = 1;
        M_PUNCT: begin
          t = two_char_type(held, c);
          if (t != T_ERROR) begin
            push_token(t, 16'd2, E_NONE); scan_mode = M_IDLE;
          end else begin
            push_lone(held); again = 1;
          end
        end
        default: again = 1;
      endcase
      if (again) scan_fresh(c);
      cur_offs = inc32(cur_offs);
      if (c == 8'd10) begin
        cur_line = inc16(cur_line); cur_col = 1;
      end else cur_col = inc16(cur_col);
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].lst = 1'b1;
    foreach (step_out[i]) expected_tokens = {expected_tokens, step_out[i]};
  endtask

  task automatic send_byte(logic k, logic [7:0] c);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1; kind <= k; ch <= c;
    @(posedge clk);
    while (stall) @(posedge clk);
    predict_tokens(k, c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(1'b0, s[i]);
  endtask

  task automatic drain();
    valid <= 1'b0;
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // receiver side stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else out_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
  end

  // compare each accepted token against the oldest prediction
  always @(posedge clk) begin
    token_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{token_type, start_line, start_column, start_offset, lexeme_length,
        error_code, last};
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token %p", got);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("token mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_text("int x = 42;\nbool b=true||false && 3.14 ;");
    send_text("namespace std::cout<<a+=b!=c->d <= >= == -- ++ iostream _id9 include\n");
    send_text("1.2.3 12abc9 x #skip this\n\"str\" \"open\n");
    send_text("@ $ ~ & | ? [ ]");
    send_byte(1'b0, 8'd0); send_byte(1'b0, 8'd255); send_byte(1'b0, 8'd128);
    send_byte(1'b0, 8'd127); send_byte(1'b0, "\"");
    send_byte(1'b1, 8'hff);
    send_text("12.5"); send_byte(1'b1, 8'h00);
    send_text("\"ab"); send_byte(1'b1, 8'h00);
    send_text("<"); send_byte(1'b1, 8'h00);
    send_text("while"); send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'h00);
    drain();
  endtask

  function automatic logic [7:0] random_byte();
    string frag = "abcxyzAZ_019.\"#\n\t =!<>&|+-:;{}()*/%,@";
    int r;
    r = $urandom_range(99, 0);
    if (r < 8) return 8'($urandom_range(255, 0));
    return frag[$urandom_range(frag.len() - 1, 0)];
  endfunction

  task automatic random_source(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99, 0);
      if (r < 30) begin
        send_text(word_text($urandom_range(NKW - 1, 0)));
        send_byte(1'b0, " ");
      end else if (r < 34) send_byte(1'b1, 8'($urandom_range(255, 0)));
      else send_byte(1'b0, random_byte());
    end
  endtask

  task automatic test_random();
    int idle_cfg[4] = '{0, 48, 0, 23};
    int stall_cfg[4] = '{0, 0, 48, 23};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_cfg[p]; stall_pct = stall_cfg[p];
      random_source(110);
      drain();
    end
    send_idle_pct = 0; stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    random_source(60);
    drain();
  endtask

  initial begin
    valid = 1'b0; kind = 1'b0; ch = 8'd0; out_stall = 1'b0;
    rst = 1'b1;
    scanner_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    if (mismatches == 0 && expected_tokens.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
